FILE: rtl/sss_pkg.sv
package sss_pkg;

    localparam int MESSAGE_DEPTH = 128;
    localparam int DIGIT_COUNT   = 8;
    localparam int POS_COUNT     = 8;

    localparam int ADDR_W  = $clog2(MESSAGE_DEPTH);
    localparam int DIG_W   = $clog2(DIGIT_COUNT);
    localparam int SWEEP_W = $clog2(MESSAGE_DEPTH + DIGIT_COUNT + 1);

    localparam int LEN_W    = 8;
    localparam int PERIOD_W = 16;
    localparam int INDEX_W  = 7;
    localparam int CHAR_W   = 8;
    localparam int SEG_W    = 8;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = POS_COUNT * SEG_W;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LENGTH      = 2'd0,
        CFG_FAST_PERIOD = 2'd1,
        CFG_SLOW_PERIOD = 2'd2
    } t_cfg_index;

    localparam logic                MODE_LOAD = 1'b0;
    localparam logic [CHAR_W-1:0]   BLANK     = 8'h20;
    localparam logic [LEN_W-1:0]    LEN_RESET  = 8'd0;
    localparam logic [PERIOD_W-1:0] FAST_RESET = 16'd500;
    localparam logic [PERIOD_W-1:0] SLOW_RESET = 16'd1000;

    localparam logic [SEG_W-1:0] DIGIT_CODES [0:9] = '{
        8'd252, 8'd96, 8'd218, 8'd242, 8'd102, 8'd182, 8'd190, 8'd224, 8'd254, 8'd246
    };

    localparam logic [SEG_W-1:0] LETTER_CODES [0:25] = '{
        8'd238, 8'd62, 8'd156, 8'd122, 8'd158, 8'd142, 8'd188, 8'd110, 8'd12, 8'd248,
        8'd174, 8'd28, 8'd1, 8'd42, 8'd58, 8'd206, 8'd230, 8'd10, 8'd182, 8'd30,
        8'd124, 8'd1, 8'd1, 8'd1, 8'd118, 8'd218
    };

    function automatic logic [SEG_W-1:0] seg_code(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] off;
        logic [SEG_W-1:0]  code;
        code = '0;
        off  = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            off  = c - 8'h30;
            code = DIGIT_CODES[off[3:0]];
        end else if (c >= 8'h41 && c <= 8'h5a) begin
            off  = c - 8'h41;
            code = LETTER_CODES[off[4:0]];
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            off  = c - 8'h61;
            code = LETTER_CODES[off[4:0]];
        end
        return code;
    endfunction

endpackage

FILE: rtl/seven_segment_scroller.sv
// Scrolls a stored message across eight seven-segment digits. Every input
// item (load or tick) yields one result: the segment codes of all digit
// positions and a flag telling whether that item moved the window. One item
// is taken per clock while the output is not stalled; its result passes
// the read register of the single-port message store and then the output
// register. Loads and ticks never touch the store in the same cycle,
// so one port serves both. The message store is not cleared at reset; read
// only entries that have been loaded. Configuration writes are taken at any
// time but should be issued only while the block is idle.
module seven_segment_scroller
    import sss_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,

    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [6:0] load_index, [14:7] load_char, [15] scroll_right, [16] fast_select
    input  logic [IN_DATA_W-1:0]   i_s_axis_tdata,
    // [0] mode
    input  logic                   i_s_axis_tuser,

    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [7:0] seg_pos0, [15:8] seg_pos1, ... [63:56] seg_pos7
    output logic [OUT_DATA_W-1:0]  o_m_axis_tdata,
    // [0] scrolled
    output logic                   o_m_axis_tuser
);

    // configuration
    logic [LEN_W-1:0]    r_len;
    logic [PERIOD_W-1:0] r_fast;
    logic [PERIOD_W-1:0] r_slow;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= LEN_RESET;
            r_fast <= FAST_RESET;
            r_slow <= SLOW_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LENGTH:      r_len  <= i_cfg_data[LEN_W-1:0];
                CFG_FAST_PERIOD: r_fast <= i_cfg_data;
                CFG_SLOW_PERIOD: r_slow <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input fields
    logic                mode;
    logic [INDEX_W-1:0]  load_index;
    logic [CHAR_W-1:0]   load_char;
    logic                scroll_right;
    logic                fast_select;

    assign mode         = i_s_axis_tuser;
    assign load_index   = i_s_axis_tdata[6:0];
    assign load_char    = i_s_axis_tdata[14:7];
    assign scroll_right = i_s_axis_tdata[15];
    assign fast_select  = i_s_axis_tdata[16];

    // pipeline control
    logic r_s1_valid;
    logic r_s1_step;
    logic r_s1_right;
    logic r_s1_fresh;   // fresh char comes from the store, else a blank
    logic r_out_valid;
    logic s1_adv;
    logic in_acc;

    assign s1_adv          = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_valid || s1_adv;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    // stage 0: tick counter, sweep position, store access
    logic [PERIOD_W-1:0] r_tick;
    logic [SWEEP_W-1:0]  r_sweep;
    logic [PERIOD_W-1:0] n_tick;
    logic [SWEEP_W-1:0]  n_sweep;
    logic [PERIOD_W-1:0] tick_inc;
    logic [PERIOD_W-1:0] period;
    logic [SWEEP_W-1:0]  len;
    logic [SWEEP_W-1:0]  span;
    logic [SWEEP_W-1:0]  sp;
    logic [SWEEP_W-1:0]  sp_next;
    logic [SWEEP_W-1:0]  rev_pos;
    logic                step;
    logic                fresh;
    logic                mem_we;
    logic                mem_re;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr;

    always_comb begin
        if (32'(r_len) > MESSAGE_DEPTH) begin
            len = SWEEP_W'(MESSAGE_DEPTH);
        end else begin
            len = SWEEP_W'(r_len);
        end
        span     = len + SWEEP_W'(DIGIT_COUNT);
        sp       = (r_sweep >= span) ? '0 : r_sweep;
        sp_next  = sp + 1'b1;
        rev_pos  = len - sp - 1'b1;
        tick_inc = r_tick + 1'b1;
        period   = fast_select ? r_fast : r_slow;
        step     = (mode != MODE_LOAD) && (tick_inc >= period);
        fresh    = sp < len;

        n_tick  = r_tick;
        n_sweep = r_sweep;
        if (in_acc && mode != MODE_LOAD) begin
            n_tick = step ? '0 : tick_inc;
            if (step) begin
                n_sweep = (sp_next >= span) ? '0 : sp_next;
            end
        end

        rd_addr = scroll_right ? rev_pos[ADDR_W-1:0] : sp[ADDR_W-1:0];
        wr_addr = load_index[ADDR_W-1:0];
        mem_re  = in_acc && step && fresh;
        mem_we  = in_acc && (mode == MODE_LOAD) && (32'(load_index) < MESSAGE_DEPTH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_sweep <= '0;
        end else begin
            r_tick  <= n_tick;
            r_sweep <= n_sweep;
        end
    end

    logic [CHAR_W-1:0] r_mem [MESSAGE_DEPTH];
    logic [CHAR_W-1:0] r_mem_rdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= load_char;
        end
        if (mem_re) begin
            r_mem_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_step  <= step;
            r_s1_right <= scroll_right;
            r_s1_fresh <= fresh;
        end
    end

    // stage 1: window shift and segment lookup
    logic [CHAR_W-1:0] r_window [DIGIT_COUNT];
    logic [CHAR_W-1:0] n_window [DIGIT_COUNT];
    logic [CHAR_W-1:0] fresh_char;
    logic              s1_fire;
    logic [OUT_DATA_W-1:0] n_out_data;

    assign s1_fire    = r_s1_valid && s1_adv;
    assign fresh_char = r_s1_fresh ? r_mem_rdata : BLANK;

    always_comb begin
        n_window = r_window;
        if (s1_fire && r_s1_step) begin
            if (!r_s1_right) begin
                for (int i = 0; i < DIGIT_COUNT - 1; i++) begin
                    n_window[i] = r_window[i + 1];
                end
                n_window[DIGIT_COUNT - 1] = fresh_char;
            end else begin
                for (int i = DIGIT_COUNT - 1; i > 0; i--) begin
                    n_window[i] = r_window[i - 1];
                end
                n_window[0] = fresh_char;
            end
        end
    end

    // position p shows window slot DIGIT_COUNT-1-p
    always_comb begin
        n_out_data = '0;
        for (int p = 0; p < POS_COUNT; p++) begin
            if (DIGIT_COUNT - 1 - p >= 0) begin
                n_out_data[p*SEG_W +: SEG_W] =
                    seg_code(n_window[DIG_W'(DIGIT_COUNT - 1 - p)]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                r_window[i] <= BLANK;
            end
        end else begin
            r_window <= n_window;
        end
    end

    // output register
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_data <= n_out_data;
            r_out_step <= r_s1_step;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_step;

`ifndef NO_ASSERTIONS
    a_sweep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_sweep) < MESSAGE_DEPTH + DIGIT_COUNT)
        else $error("sweep position out of range");

    a_load_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && mode == MODE_LOAD |=> r_s1_valid && !r_s1_step)
        else $error("load item marked as scroll step");

    a_step_clears_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && step |=> r_tick == '0)
        else $error("tick counter not restarted after step");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_axis_tready |=> r_out_valid && $stable(r_out_data))
        else $error("pending result lost");

    a_flag_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> r_out_valid && o_m_axis_tuser == $past(r_s1_step))
        else $error("scrolled flag mismatch");

    a_s1_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_mem_rdata))
        else $error("stalled store data overwritten");
`endif

endmodule
